FILE: rtl/lew_pkg.sv
// ----------------------------------------------------------------------------
// lew_pkg
// shared widths, reset values, register indexes and types of the lane edge
// window tracker
// ----------------------------------------------------------------------------
package lew_pkg;

  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int WID_W = COL_W + 1;
  localparam int TOL_W = COL_W;
  localparam int PIX_W = 8;
  localparam int CFG_W = WID_W;

  localparam logic [TOL_W-1:0] TOL_RESET   = TOL_W'(40);
  localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(640);
  localparam logic [WID_W-1:0] WIDTH_MAX   = WID_W'(MAX_COLUMNS);

  typedef enum logic [0:0] {
    REG_TOLERANCE   = 1'b0,
    REG_IMAGE_WIDTH = 1'b1
  } lew_reg_idx_t;

  // configuration as the datapath uses it
  typedef struct packed {
    logic [TOL_W-1:0] tol;
    logic [COL_W-1:0] wm1;   // effective width minus one
    logic [COL_W-1:0] half;  // effective width over two
  } lew_cfg_t;

  // reference source handed from the row tracker to the window logic
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] center;
  } lew_ref_t;

  // search window of the current row
  typedef struct packed {
    logic [COL_W-1:0] refc;
    logic [COL_W-1:0] lo;
    logic [COL_W-1:0] hi;
  } lew_win_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             left_found;
    logic [COL_W-1:0] left_column;
    logic             right_found;
    logic [COL_W-1:0] right_column;
    logic             center_found;
    logic [COL_W-1:0] center_column;
  } lew_result_t;

endpackage

FILE: rtl/lew_ifs.sv
// ----------------------------------------------------------------------------
// lew channel interfaces
// pixel, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface lew_in_if
  import lew_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] mask_value;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row_index;
  logic             frame_start;
  logic             row_end;

  modport source (output valid, mask_value, column, row_index, frame_start, row_end,
                  input ready);
  modport sink   (input valid, mask_value, column, row_index, frame_start, row_end,
                  output ready);
endinterface

interface lew_out_if
  import lew_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] result_row;
  logic             left_found;
  logic [COL_W-1:0] left_column;
  logic             right_found;
  logic [COL_W-1:0] right_column;
  logic             center_found;
  logic [COL_W-1:0] center_column;

  modport source (output valid, result_row, left_found, left_column, right_found,
                         right_column, center_found, center_column,
                  input ready);
  modport sink   (input valid, result_row, left_found, left_column, right_found,
                        right_column, center_found, center_column,
                  output ready);
endinterface

interface lew_cfg_if
  import lew_pkg::*;
();
  logic             valid;
  logic             ready;
  lew_reg_idx_t     index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/lew_cfg_regs.sv
// ----------------------------------------------------------------------------
// lew_cfg_regs
// configuration registers; width is saturated and pre-decoded at write time
// ----------------------------------------------------------------------------
module lew_cfg_regs
  import lew_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  lew_cfg_if.sink       cfg_chan,
  output lew_cfg_t      cfg
);

  logic [TOL_W-1:0] tol_r;
  logic [COL_W-1:0] wm1_r;
  logic [COL_W-1:0] half_r;
  logic [WID_W-1:0] width_sat;
  logic [WID_W-1:0] width_m1;

  assign cfg_chan.ready = 1'b1;

  // zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (cfg_chan.data == '0) begin
      width_sat = WID_W'(1);
    end else if (cfg_chan.data > WIDTH_MAX) begin
      width_sat = WIDTH_MAX;
    end else begin
      width_sat = cfg_chan.data;
    end
    width_m1 = width_sat - WID_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= TOL_RESET;
      wm1_r  <= COL_W'(WIDTH_RESET - WID_W'(1));
      half_r <= COL_W'(WIDTH_RESET >> 1);
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        REG_TOLERANCE: begin
          tol_r <= cfg_chan.data[TOL_W-1:0];
        end
        REG_IMAGE_WIDTH: begin
          wm1_r  <= width_m1[COL_W-1:0];
          half_r <= width_sat[WID_W-1:1];
        end
      endcase
    end
  end

  assign cfg.tol  = tol_r;
  assign cfg.wm1  = wm1_r;
  assign cfg.half = half_r;

endmodule

FILE: rtl/lew_window.sv
// ----------------------------------------------------------------------------
// lew_window
// reference column and clamped search window of the current row
// ----------------------------------------------------------------------------
module lew_window
  import lew_pkg::*;
(
  input  lew_cfg_t  cfg,
  input  lew_ref_t  refsrc,
  output lew_win_t  win
);

  logic [COL_W-1:0] ref_raw;
  logic [COL_W-1:0] ref_sat;
  logic [WID_W-1:0] hi_sum;

  always_comb begin
    ref_raw = refsrc.valid ? refsrc.center : cfg.half;
    ref_sat = (ref_raw > cfg.wm1) ? cfg.wm1 : ref_raw;
    hi_sum  = {1'b0, ref_sat} + {1'b0, cfg.tol};

    win.refc = ref_sat;
    win.lo   = (ref_sat > cfg.tol) ? (ref_sat - cfg.tol) : '0;
    win.hi   = (hi_sum > {1'b0, cfg.wm1}) ? cfg.wm1 : hi_sum[COL_W-1:0];
  end

endmodule

FILE: rtl/lew_row_tracker.sv
// ----------------------------------------------------------------------------
// lew_row_tracker
// pixel input register, per-row candidates, kept center and result register
// ----------------------------------------------------------------------------
module lew_row_tracker
  import lew_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lew_in_if.sink    in_chan,
  lew_out_if.source out_chan,
  input  lew_win_t  win,
  output lew_ref_t  refsrc
);

  // input register
  logic             in_valid_r;
  logic [PIX_W-1:0] pix_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             fs_r;
  logic             re_r;

  // tracking state
  logic             kv_r;
  logic [COL_W-1:0] kc_r;
  logic             lv_r;
  logic [COL_W-1:0] lc_r;
  logic             rv_r;
  logic [COL_W-1:0] rc_r;

  // result register
  logic             out_valid_r;
  lew_result_t      res_r;
  lew_result_t      res_nxt;

  logic             in_acc;
  logic             out_free;
  logic             advance;
  logic             kv_eff;
  logic             lv_eff;
  logic             rv_eff;
  logic             hit;
  logic             l_take;
  logic             r_take;
  logic             lv_nxt;
  logic             rv_nxt;
  logic [COL_W-1:0] lc_nxt;
  logic [COL_W-1:0] rc_nxt;
  logic             both;
  logic [WID_W-1:0] sum;

  assign out_free = !out_valid_r || out_chan.ready;
  assign advance  = in_valid_r && (!re_r || out_free);
  assign in_chan.ready = !in_valid_r || advance;
  assign in_acc   = in_chan.valid && in_chan.ready;

  // frame start forgets the kept center and any partial row
  assign kv_eff = kv_r && !fs_r;
  assign lv_eff = lv_r && !fs_r;
  assign rv_eff = rv_r && !fs_r;

  assign refsrc.valid  = kv_eff;
  assign refsrc.center = kc_r;

  always_comb begin
    hit    = (pix_r != '0);
    l_take = hit && (col_r >= win.lo) && (col_r <= win.refc);
    r_take = hit && (col_r >= win.refc) && (col_r <= win.hi) && !rv_eff;
    lv_nxt = lv_eff || l_take;
    rv_nxt = rv_eff || r_take;
    lc_nxt = l_take ? col_r : lc_r;
    rc_nxt = r_take ? col_r : rc_r;
    both   = lv_nxt && rv_nxt;
    sum    = {1'b0, lc_nxt} + {1'b0, rc_nxt};

    res_nxt.row           = row_r;
    res_nxt.left_found    = lv_nxt;
    res_nxt.left_column   = lv_nxt ? lc_nxt : '0;
    res_nxt.right_found   = rv_nxt;
    res_nxt.right_column  = rv_nxt ? rc_nxt : '0;
    res_nxt.center_found  = both;
    res_nxt.center_column = both ? sum[WID_W-1:1] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      kv_r        <= 1'b0;
      kc_r        <= '0;
      lv_r        <= 1'b0;
      lc_r        <= '0;
      rv_r        <= 1'b0;
      rc_r        <= '0;
    end else begin
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end

      if (advance && re_r) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      if (advance) begin
        lc_r <= lc_nxt;
        rc_r <= rc_nxt;
        if (re_r) begin
          lv_r <= 1'b0;
          rv_r <= 1'b0;
          if (both) begin
            kv_r <= 1'b1;
            kc_r <= sum[WID_W-1:1];
          end else begin
            kv_r <= kv_eff;
          end
        end else begin
          lv_r <= lv_nxt;
          rv_r <= rv_nxt;
          kv_r <= kv_eff;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r <= in_chan.mask_value;
      col_r <= in_chan.column;
      row_r <= in_chan.row_index;
      fs_r  <= in_chan.frame_start;
      re_r  <= in_chan.row_end;
    end
    if (advance && re_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.result_row    = res_r.row;
  assign out_chan.left_found    = res_r.left_found;
  assign out_chan.left_column   = res_r.left_column;
  assign out_chan.right_found   = res_r.right_found;
  assign out_chan.right_column  = res_r.right_column;
  assign out_chan.center_found  = res_r.center_found;
  assign out_chan.center_column = res_r.center_column;

endmodule

FILE: rtl/lane_edge_window_tracker.sv
// a row-end word is first held in the input register and its result word then in
//   the result register, which offers it until the receiver takes it
// throughput: one pixel word per cycle; a row-end word waits only while a
//   result sits unaccepted in the result register
// the pixel path is one input register, window compares and one result register
// reset (rst_n low, synchronous): both channels empty, kept center and row
//   candidates cleared, tolerance 40 and width 640
// ----------------------------------------------------------------------------
// lane_edge_window_tracker
// tracks left and right lane edges around a moving reference column, one
// result word per row
// ----------------------------------------------------------------------------
module lane_edge_window_tracker
  import lew_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lew_in_if.sink    in_chan,
  lew_out_if.source out_chan,
  lew_cfg_if.sink   cfg_chan
);

  // saturated width minus one, half width and tolerance
  lew_cfg_t cfg;
  // reference source: kept center, if any survives a frame start
  lew_ref_t refsrc;
  // window of the word sitting in the input register
  lew_win_t win;

  lew_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // reference is the kept center or half the width, clamped to the row,
  // window clamped to zero and width minus one
  lew_window u_win (
    .cfg    (cfg),
    .refsrc (refsrc),
    .win    (win)
  );

  // left keeps the last hit at or below the reference, right the first at
  // or above it; a row end emits the word and keeps the midpoint if both hit
  lew_row_tracker u_trk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .win      (win),
    .refsrc   (refsrc)
  );

endmodule

FILE: rtl/lew_checker.sv
// ----------------------------------------------------------------------------
// lew_checker
// port-level checks of the lane edge window tracker
// ----------------------------------------------------------------------------
module lew_checker
  import lew_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_row_end,
  input logic             out_valid,
  input logic             out_ready,
  input logic             left_found,
  input logic [COL_W-1:0] left_column,
  input logic             right_found,
  input logic [COL_W-1:0] right_column,
  input logic             center_found,
  input logic [COL_W-1:0] center_column
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(center_column)
      && $stable(left_column) && $stable(right_column))
    else $error("result word changed while stalled");

  // a fresh result comes from a row-end word taken into the input register
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_row_end, 2))
    else $error("result without a row-end word");

  a_center_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> center_found == (left_found && right_found))
    else $error("center flag disagrees with edge flags");

  // midpoint lies between the left and right edge columns
  a_center_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && center_found |-> left_column <= center_column
      && center_column <= right_column)
    else $error("center outside the edges");

endmodule

bind lane_edge_window_tracker lew_checker u_lew_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_row_end    (in_chan.row_end),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .left_found    (out_chan.left_found),
  .left_column   (out_chan.left_column),
  .right_found   (out_chan.right_found),
  .right_column  (out_chan.right_column),
  .center_found  (out_chan.center_found),
  .center_column (out_chan.center_column)
);

FILE: bench/tb_lane_edge_window_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lane_edge_window_tracker
// drives mask pixel words through the lane edge window tracker under random
// sender gaps and receiver stalls, predicts every row result and checks each
// result word field by field, over several window and width settings
// ----------------------------------------------------------------------------
module tb_lane_edge_window_tracker;
  import lew_pkg::*;

  localparam int PHASE_WORDS   = 150;  // minimum of random pixel words per setting
  localparam int SETTLE_CYCLES = 8;    // idle wait after the last result is taken

  // one pixel word as it goes onto the input channel
  typedef struct packed {
    logic [PIX_W-1:0] mask;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             fs;
    logic             re;
  } pixel_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lew_in_if  in_if();
  lew_out_if out_if();
  lew_cfg_if cfg_if();

  lane_edge_window_tracker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #2 clk = ~clk;

  // words waiting for the driver, and row results still owed by the block
  pixel_word_t pixel_q[$];
  lew_result_t row_result_q[$];
  int unsigned err_cnt = 0;

  // register copy and tracker state as the block should hold them
  logic [TOL_W-1:0] tol_m;
  logic [WID_W-1:0] width_m;
  logic [COL_W-1:0] kept_ctr;
  logic             kept_ok;
  logic [COL_W-1:0] left_col;
  logic             left_ok;
  logic [COL_W-1:0] right_col;
  logic             right_ok;

  // settings as the stimulus side last wrote them, used only to shape rows
  int cur_tol;
  int cur_width;
  int row_no;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch, %s", $time, msg);
    err_cnt++;
  endtask

  // advance the tracker by one accepted pixel word; returns 1 when the word
  // closes a row, with the result the block owes for it
  function automatic bit track_pixel(input pixel_word_t p, output lew_result_t res);
    int unsigned ew;
    int unsigned refc;
    int unsigned lo;
    int unsigned hi;
    bit          both;
    res = '0;
    // width register is used clamped to 1..MAX_COLUMNS
    ew = width_m;
    if (ew == 0) ew = 1;
    if (ew > MAX_COLUMNS) ew = MAX_COLUMNS;
    // frame start drops the kept center and any partial row before the pixel
    if (p.fs) begin
      kept_ok   = 1'b0;
      left_ok   = 1'b0;
      right_ok  = 1'b0;
      left_col  = '0;
      right_col = '0;
    end
    // reference saturates to the last column when the kept center is beyond it
    refc = kept_ok ? kept_ctr : ew / 2;
    if (refc > ew - 1) refc = ew - 1;
    lo = (refc > tol_m) ? refc - tol_m : 0;
    hi = refc + tol_m;
    if (hi > ew - 1) hi = ew - 1;
    // left keeps the last hit, right keeps the first; the reference counts for both
    if (p.mask != 0) begin
      if (p.col >= lo && p.col <= refc) begin
        left_col = p.col;
        left_ok  = 1'b1;
      end
      if (p.col >= refc && p.col <= hi && !right_ok) begin
        right_col = p.col;
        right_ok  = 1'b1;
      end
    end
    if (!p.re) return 1'b0;
    both              = left_ok && right_ok;
    res.row           = p.row;
    res.left_found    = left_ok;
    res.left_column   = left_ok ? left_col : '0;
    res.right_found   = right_ok;
    res.right_column  = right_ok ? right_col : '0;
    res.center_found  = both;
    res.center_column = both ? COL_W'((int'(left_col) + int'(right_col)) >> 1) : '0;
    if (both) begin
      kept_ctr = res.center_column;
      kept_ok  = 1'b1;
    end
    left_ok   = 1'b0;
    right_ok  = 1'b0;
    left_col  = '0;
    right_col = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- driver
  // sends in bursts of random length with random gaps; a zero gap now and
  // then gives long stretches at full rate
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin : pixel_driver
    pixel_word_t p;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0 || pixel_q.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_if.valid <= 1'b0;
      end else begin
        p = pixel_q.pop_front();
        in_if.mask_value  <= p.mask;
        in_if.column      <= p.col;
        in_if.row_index   <= p.row;
        in_if.frame_start <= p.fs;
        in_if.row_end     <= p.re;
        in_if.valid       <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  // ready follows the bits of a 16-bit pattern in turn, reloaded each time it runs out
  logic [15:0] stall_pat;
  int unsigned pat_pos;

  always @(posedge clk) begin : result_sink
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_pat = '1;
      pat_pos   = 0;
    end else begin
      if (pat_pos == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = 16'h00ff;
        endcase
      end
      out_if.ready <= stall_pat[pat_pos];
      pat_pos = (pat_pos + 1) % 16;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : chan_monitor
    pixel_word_t p;
    lew_result_t res;
    lew_result_t want;
    if (!rst_n) begin
      tol_m     = TOL_RESET;
      width_m   = WIDTH_RESET;
      kept_ctr  = '0;
      kept_ok   = 1'b0;
      left_col  = '0;
      left_ok   = 1'b0;
      right_col = '0;
      right_ok  = 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_TOLERANCE:   tol_m   = cfg_if.data[TOL_W-1:0];
          REG_IMAGE_WIDTH: width_m = cfg_if.data;
          default: ;
        endcase
      end
      // results are checked before this edge's pixel can add a new expectation
      if (out_if.valid && out_if.ready) begin
        if (row_result_q.size() == 0) begin
          report_mismatch($sformatf("result word for row %0d with none pending",
                                    out_if.result_row));
        end else begin
          want = row_result_q.pop_front();
          if (out_if.result_row !== want.row)
            report_mismatch($sformatf("result_row got %0d, expected %0d",
                                      out_if.result_row, want.row));
          if (out_if.left_found !== want.left_found)
            report_mismatch($sformatf("row %0d left_found got %0d, expected %0d",
                                      want.row, out_if.left_found, want.left_found));
          if (out_if.left_column !== want.left_column)
            report_mismatch($sformatf("row %0d left_column got %0d, expected %0d",
                                      want.row, out_if.left_column, want.left_column));
          if (out_if.right_found !== want.right_found)
            report_mismatch($sformatf("row %0d right_found got %0d, expected %0d",
                                      want.row, out_if.right_found, want.right_found));
          if (out_if.right_column !== want.right_column)
            report_mismatch($sformatf("row %0d right_column got %0d, expected %0d",
                                      want.row, out_if.right_column, want.right_column));
          if (out_if.center_found !== want.center_found)
            report_mismatch($sformatf("row %0d center_found got %0d, expected %0d",
                                      want.row, out_if.center_found, want.center_found));
          if (out_if.center_column !== want.center_column)
            report_mismatch($sformatf("row %0d center_column got %0d, expected %0d",
                                      want.row, out_if.center_column, want.center_column));
        end
      end
      if (in_if.valid && in_if.ready) begin
        p = '{mask: in_if.mask_value, col: in_if.column, row: in_if.row_index,
              fs: in_if.frame_start, re: in_if.row_end};
        if (track_pixel(p, res)) row_result_q.insert(row_result_q.size(), res);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic push_pixel(input int mask, input int col, input int row,
                            input bit fs, input bit re);
    pixel_word_t w;
    w = '{mask: PIX_W'(mask), col: COL_W'(col), row: ROW_W'(row), fs: fs, re: re};
    pixel_q.insert(pixel_q.size(), w);
  endtask

  // one row of pixel words: mostly a full scan or a sparse ascending pass
  // around the middle of the row, sometimes scattered columns anywhere
  task automatic add_random_row(input int ew, input bit fs_first, inout int words);
    int cols[$];
    int kind;
    int hs;
    int lo;
    int hi;
    int col;
    int stepmax;
    int n;
    bit noise;
    bit fs;
    kind  = $urandom_range(0, 99);
    noise = (kind >= 85);
    fs    = fs_first || ($urandom_range(0, 9) == 0);
    row_no = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095) : (row_no + 1) % 4096;
    if (noise) begin
      // out of order, often past the row width
      n = $urandom_range(1, 8);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0) cols.insert(cols.size(), $urandom_range(0, ew - 1));
        else cols.insert(cols.size(), $urandom_range(0, 4095));
      end
    end else if (ew <= 48 && kind < 50) begin
      for (int c = 0; c < ew; c++) cols.insert(cols.size(), c);
    end else begin
      hs = cur_tol + 4;
      lo = (ew / 2 > hs) ? ew / 2 - hs : 0;
      hi = (ew / 2 + hs > ew - 1) ? ew - 1 : ew / 2 + hs;
      n  = $urandom_range(2, 12);
      stepmax = ((hi - lo) / n > 1) ? (hi - lo) / n : 1;
      col = lo + $urandom_range(0, stepmax - 1);
      while (col <= hi) begin
        cols.insert(cols.size(), col);
        col += $urandom_range(1, stepmax);
      end
      if (cols.size() == 0) cols.insert(cols.size(), hi);
    end
    foreach (cols[i]) begin
      push_pixel(noise ? $urandom_range(0, 255)
                       : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 255) : 0),
                 cols[i], row_no, fs && (i == 0), i == cols.size() - 1);
    end
    words += cols.size();
  endtask

  task automatic run_random(input int target);
    int words;
    int ew;
    bit first;
    words = 0;
    ew = (cur_width == 0) ? 1 : ((cur_width > MAX_COLUMNS) ? MAX_COLUMNS : cur_width);
    first = ($urandom_range(0, 1) == 0);
    while (words < target) begin
      add_random_row(ew, first, words);
      first = 1'b0;
    end
  endtask

  // block idle: nothing queued, nothing in flight, nothing owed, then settle
  task automatic wait_idle();
    @(negedge clk);
    while (pixel_q.size() != 0 || in_if.valid || row_result_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input lew_reg_idx_t idx, input int val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_W'(val);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_window(input int tol, input int width);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_IMAGE_WIDTH, width);
    cur_tol   = tol;
    cur_width = width;
    @(negedge clk);
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.mask_value  = '0;
    in_if.column      = '0;
    in_if.row_index   = '0;
    in_if.frame_start = 1'b0;
    in_if.row_end     = 1'b0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_TOLERANCE;
    cfg_if.data       = '0;
    cur_tol   = 40;
    cur_width = 640;
    row_no    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: reference 320, window 280..360
    push_pixel(8'h01, 279, 10, 1, 0);       // one left of the window
    push_pixel(8'h80, 280, 10, 0, 0);       // left window edge
    push_pixel(8'h00, 320, 10, 0, 0);
    push_pixel(8'h01, 361, 10, 0, 0);       // one right of the window
    push_pixel(8'hff, 360, 10, 0, 1);       // right edge, center 320
    push_pixel(8'h01, 320, 11, 0, 1);       // pixel on the reference, both sides
    push_pixel(8'h05, 330, 12, 0, 0);       // columns out of order
    push_pixel(8'h07, 325, 12, 0, 0);
    push_pixel(8'h03, 300, 12, 0, 0);
    push_pixel(8'h09, 310, 12, 0, 0);
    push_pixel(8'hff, 4095, 4095, 0, 1);    // far past the width, ignored
    push_pixel(8'h01, 300, 12'h555, 0, 0);  // partial row dropped by frame start
    push_pixel(8'h00, 0, 12'h555, 1, 0);
    push_pixel(8'h00, 4095, 12'haaa, 0, 1); // nothing found
    push_pixel(8'h02, 319, 12'h0ff, 0, 1);  // left only
    push_pixel(8'h40, 345, 12'hf00, 0, 1);  // right only
    run_random(PHASE_WORDS);
    wait_idle();

    // widest window over the full width; leaves the kept center at 2047
    set_window(4095, 4096);
    run_random(PHASE_WORDS);
    push_pixel(8'h01, 0, 100, 1, 0);
    push_pixel(8'h01, 4095, 101, 0, 1);
    wait_idle();

    // narrow width with the kept center beyond it: reference saturates to 99
    set_window(5, 100);
    push_pixel(8'h10, 99, 200, 0, 1);
    push_pixel(8'h20, 94, 201, 0, 0);
    push_pixel(8'h08, 93, 201, 0, 1);
    run_random(PHASE_WORDS);
    wait_idle();

    // single column, zero tolerance
    set_window(0, 1);
    push_pixel(8'h01, 0, 300, 1, 1);
    push_pixel(8'h01, 1, 301, 0, 1);
    run_random(PHASE_WORDS);
    wait_idle();

    // width zero acts as one
    set_window(3, 0);
    push_pixel(8'h04, 0, 400, 1, 1);
    run_random(PHASE_WORDS);
    wait_idle();

    // width register above the maximum clamps to it
    set_window(2, 8191);
    push_pixel(8'h01, 2048, 500, 1, 1);
    run_random(PHASE_WORDS);
    wait_idle();

    // random settings, mostly short rows
    repeat (7) begin
      case ($urandom_range(0, 4))
        0, 1, 2: cur_width = $urandom_range(2, 48);
        3:       cur_width = $urandom_range(49, 700);
        default: cur_width = $urandom_range(0, 8191);
      endcase
      cur_tol = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 12);
      set_window(cur_tol, cur_width);
      run_random(PHASE_WORDS);
      wait_idle();
    end

    if (err_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: lane_edge_window_tracker.f
rtl/lew_pkg.sv
rtl/lew_ifs.sv
rtl/lew_cfg_regs.sv
rtl/lew_window.sv
rtl/lew_row_tracker.sv
rtl/lane_edge_window_tracker.sv
rtl/lew_checker.sv
bench/tb_lane_edge_window_tracker.sv
